@@ rtl/core/tccs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console package
// Geometry, field widths, operation codes, character codes and the store
// access request shared by the console sequencer and the cell store.
// ----------------------------------------------------------------------------
package tccs_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CLR_W  = 4;
	localparam int CFG_W  = 1;

	localparam logic [OP_W-1:0] OP_PUT     = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
	localparam logic [OP_W-1:0] OP_NEWLINE = 2'd2;
	localparam logic [OP_W-1:0] OP_READ    = 2'd3;

	localparam logic [CFG_W-1:0] REG_FG = 1'd0;
	localparam logic [CFG_W-1:0] REG_BG = 1'd1;

	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

	localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
	localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

@@ rtl/core/text_console_cursor_scroll_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor and scroll unit
// Put, carriage return, line feed, newline and read items pass through the
// execute state to the done strobe; a new item may start in the done cycle.
// Scrolling copies the store up one row through its read and write ports,
// then blanks the bottom row. Clear sweeps every cell.
// After reset, busy stays high while the store is zeroed; configuration
// writes are taken throughout. The receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tccs_pkg::OP_W-1:0]     operation,
	input  logic [tccs_pkg::CHAR_W-1:0]   character,
	input  logic [tccs_pkg::IDX_W-1:0]    cell_index,
	output logic                          done,
	output logic [tccs_pkg::CELL_W-1:0]   read_cell,
	output logic [tccs_pkg::ROW_W-1:0]    cursor_row,
	output logic [tccs_pkg::COL_W-1:0]    cursor_col,
	output logic                          scrolled,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tccs_pkg::CFG_W-1:0]    cfg_index,
	input  logic [tccs_pkg::CLR_W-1:0]    cfg_data
);
	import tccs_pkg::*;

	mem_req_t          req;
	logic [CELL_W-1:0] rdata;

	tccs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.character  (character),
		.cell_index (cell_index),
		.done       (done),
		.read_cell  (read_cell),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req),
		.rdata      (rdata)
	);

	tccs_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule

@@ rtl/core/tccs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell store
// One write port and one registered read port over the character cells.
// ----------------------------------------------------------------------------
module tccs_ram (
	input  logic                   clk,
	input  tccs_pkg::mem_req_t     req,
	output logic [tccs_pkg::CELL_W-1:0] rdata
);
	import tccs_pkg::*;

	logic [CELL_W-1:0] mem_q [CELL_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

@@ rtl/core/tccs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console sequencer
// Cursor, colour registers and the sequencer that drives the store's write
// and read ports for writes, reads, scrolling copies and fill sweeps.
// ----------------------------------------------------------------------------
module tccs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tccs_pkg::OP_W-1:0]     operation,
	input  logic [tccs_pkg::CHAR_W-1:0]   character,
	input  logic [tccs_pkg::IDX_W-1:0]    cell_index,
	output logic                          done,
	output logic [tccs_pkg::CELL_W-1:0]   read_cell,
	output logic [tccs_pkg::ROW_W-1:0]    cursor_row,
	output logic [tccs_pkg::COL_W-1:0]    cursor_col,
	output logic                          scrolled,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tccs_pkg::CFG_W-1:0]    cfg_index,
	input  logic [tccs_pkg::CLR_W-1:0]    cfg_data,
	output tccs_pkg::mem_req_t            req,
	input  logic [tccs_pkg::CELL_W-1:0]   rdata
);
	import tccs_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SCROLL = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_FILL   = 3'd4;

	localparam logic [IDX_W:0]  CELL_LIMIT = (IDX_W+1)'(CELL_COUNT);
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] ROW_ONE    = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

	logic [2:0]        state_q;
	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CLR_W-1:0]  fg_q;
	logic [CLR_W-1:0]  bg_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] waddr_q;
	logic [CELL_W-1:0] fill_word_q;
	logic              pend_q;
	logic              init_q;
	logic              done_q;
	logic              sel_q;
	logic              scrolled_q;

	logic              is_ctrl_ch;
	logic              print_ch;
	logic              adv;
	logic              read_hit;
	logic [ADDR_W-1:0] put_addr;
	logic [CELL_W-1:0] blank_word;

	assign is_ctrl_ch = (ch_q == CHAR_LF) || (ch_q == CHAR_CR);
	assign print_ch   = (op_q == OP_PUT) && !is_ctrl_ch;
	assign adv        = (op_q == OP_NEWLINE) || ((op_q == OP_PUT) && (ch_q == CHAR_LF))
		|| (print_ch && (col_q == LAST_COL));
	assign read_hit   = {1'b0, idx_q} < CELL_LIMIT;
	assign put_addr   = ADDR_W'(row_q * COLUMNS) + ADDR_W'(col_q);
	assign blank_word = {bg_q, fg_q, CHAR_BLANK};

	assign busy       = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign read_cell  = (done_q && sel_q) ? rdata : '0;
	assign cursor_row = row_q;
	assign cursor_col = col_q;
	assign scrolled   = done_q && scrolled_q;

	always_comb begin
		req = '0;
		case (state_q)
			S_EXEC: begin
				if (print_ch) begin
					req.we    = 1'b1;
					req.waddr = put_addr;
					req.wdata = {bg_q, fg_q, ch_q};
				end else if ((op_q == OP_READ) && read_hit) begin
					req.re    = 1'b1;
					req.raddr = ADDR_W'(idx_q);
				end
			end
			S_SCROLL: begin
				req.re    = 1'b1;
				req.raddr = cnt_q;
				req.we    = pend_q;
				req.waddr = waddr_q;
				req.wdata = rdata;
			end
			S_DRAIN: begin
				req.we    = pend_q;
				req.waddr = waddr_q;
				req.wdata = rdata;
			end
			S_FILL: begin
				req.we    = 1'b1;
				req.waddr = cnt_q;
				req.wdata = fill_word_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			cnt_q       <= '0;
			fill_word_q <= '0;
			init_q      <= 1'b1;
			pend_q      <= 1'b0;
			done_q      <= 1'b0;
			sel_q       <= 1'b0;
			scrolled_q  <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			fg_q        <= FG_RESET;
			bg_q        <= BG_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_FG:  fg_q <= cfg_data;
					REG_BG:  bg_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q       <= operation;
						ch_q       <= character;
						idx_q      <= cell_index;
						sel_q      <= 1'b0;
						scrolled_q <= 1'b0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_CLEAR) begin
						row_q       <= '0;
						col_q       <= '0;
						cnt_q       <= '0;
						fill_word_q <= blank_word;
						state_q     <= S_FILL;
					end else if (adv) begin
						col_q <= '0;
						if (row_q == LAST_ROW) begin
							scrolled_q  <= 1'b1;
							pend_q      <= 1'b0;
							fill_word_q <= blank_word;
							if (ROWS > 1) begin
								cnt_q   <= ROW_ONE;
								state_q <= S_SCROLL;
							end else begin
								cnt_q   <= BOTTOM_ROW;
								state_q <= S_FILL;
							end
						end else begin
							row_q   <= row_q + 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						if (print_ch) begin
							col_q <= col_q + 1'b1;
						end else if (op_q == OP_PUT) begin
							col_q <= '0;
						end
						sel_q   <= (op_q == OP_READ) && read_hit;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCROLL: begin
					pend_q  <= 1'b1;
					waddr_q <= cnt_q - ROW_ONE;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == LAST_CELL) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					pend_q  <= 1'b0;
					cnt_q   <= BOTTOM_ROW;
					state_q <= S_FILL;
				end
				S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CELL) begin
						state_q <= S_IDLE;
						if (init_q) begin
							init_q <= 1'b0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sim/text_console_cursor_scroll_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor and scroll unit testbench
// Drives put, clear, newline and read items through the start/busy handshake
// and checks every done strobe against an in-bench model of the screen store,
// cursor and colours, or its pinned directed result. A short directed list
// comes first, then four random runs under different colours and sender gaps.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit_test;
	import tccs_pkg::*;

	localparam int STALL_LIMIT = 8 * CELL_COUNT + 1000;

	typedef struct packed {
		logic [CELL_W-1:0] cell_val;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              scrolled;
	} console_result_t;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		bit                pinned;
		logic [CELL_W-1:0] cell_val;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              scr;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [OP_W-1:0]     operation;
	logic [CHAR_W-1:0]   character;
	logic [IDX_W-1:0]    cell_index;
	logic                done;
	logic [CELL_W-1:0]   read_cell;
	logic [ROW_W-1:0]    cursor_row;
	logic [COL_W-1:0]    cursor_col;
	logic                scrolled;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_index;
	logic [CLR_W-1:0]    cfg_data;

	logic [CELL_W-1:0]   screen [CELL_COUNT];
	int unsigned         row_now;
	int unsigned         col_now;
	logic [CLR_W-1:0]    fg_now;
	logic [CLR_W-1:0]    bg_now;

	console_result_t     pending_results [$];
	stim_row_t           directed_rows [$];
	bit                  pin_now;
	console_result_t     pin_result;
	int                  idle_pct;
	int                  fault_count;
	int                  stall_count;

	text_console_cursor_scroll_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.character  (character),
		.cell_index (cell_index),
		.done       (done),
		.read_cell  (read_cell),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [CELL_W-1:0] coloured(input logic [CHAR_W-1:0] ch);
		return {bg_now, fg_now, ch};
	endfunction

	function automatic logic line_advance();
		col_now = 0;
		if (row_now < ROWS - 1) begin
			row_now++;
			return 1'b0;
		end
		for (int i = COLUMNS; i < CELL_COUNT; i++)
			screen[i - COLUMNS] = screen[i];
		for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
			screen[i] = coloured(CHAR_BLANK);
		return 1'b1;
	endfunction

	function automatic console_result_t console_step(input logic [OP_W-1:0] op,
			input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
		console_result_t r;
		logic scr;
		r = '0;
		scr = 1'b0;
		case (op)
			OP_PUT: begin
				if (ch == CHAR_LF) begin
					scr = line_advance();
				end else if (ch == CHAR_CR) begin
					col_now = 0;
				end else begin
					screen[row_now * COLUMNS + col_now] = coloured(ch);
					col_now++;
					if (col_now >= COLUMNS)
						scr = line_advance();
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen[i] = coloured(CHAR_BLANK);
				row_now = 0;
				col_now = 0;
			end
			OP_NEWLINE: begin
				scr = line_advance();
			end
			OP_READ: begin
				if (idx < CELL_COUNT)
					r.cell_val = screen[idx];
			end
			default: begin
			end
		endcase
		r.row = ROW_W'(row_now);
		r.col = COL_W'(col_now);
		r.scrolled = scr;
		return r;
	endfunction

	function automatic void flag_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	always @(posedge clk) begin
		console_result_t got;
		console_result_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					REG_FG: fg_now = cfg_data;
					REG_BG: bg_now = cfg_data;
					default: begin
					end
				endcase
			end
			if (done) begin
				moved = 1'b1;
				got.cell_val = read_cell;
				got.row = cursor_row;
				got.col = cursor_col;
				got.scrolled = scrolled;
				if (pending_results.size() == 0) begin
					flag_fault("done strobe with no item outstanding");
				end else begin
					want = pending_results.pop_front();
					if (got.cell_val !== want.cell_val)
						flag_fault($sformatf("read_cell: expected %h, got %h",
							want.cell_val, got.cell_val));
					if (got.row !== want.row)
						flag_fault($sformatf("cursor_row: expected %0d, got %0d",
							want.row, got.row));
					if (got.col !== want.col)
						flag_fault($sformatf("cursor_col: expected %0d, got %0d",
							want.col, got.col));
					if (got.scrolled !== want.scrolled)
						flag_fault($sformatf("scrolled: expected %b, got %b",
							want.scrolled, got.scrolled));
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				want = console_step(operation, character, cell_index);
				pending_results.push_back(pin_now ? pin_result : want);
			end
			stall_count = moved ? 0 : stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx, input bit pinned, input console_result_t res);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		operation = op;
		character = ch;
		cell_index = idx;
		pin_now = pinned;
		pin_result = res;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (pending_results.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_colour(input logic [CFG_W-1:0] sel, input logic [CLR_W-1:0] value);
		cfg_index = sel;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_random(input int count);
		int burst_left;
		int pick;
		int sub;
		logic [OP_W-1:0] op;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0] idx;
		burst_left = 0;
		repeat (count) begin
			op = OP_PUT;
			ch = CHAR_W'($urandom_range(255));
			idx = IDX_W'($urandom_range(2047));
			if (burst_left == 0 && $urandom_range(199) == 0)
				burst_left = $urandom_range(40, 170);
			if (burst_left != 0) begin
				ch = CHAR_W'($urandom_range(8'h21, 8'h7e));
				burst_left--;
			end else begin
				pick = $urandom_range(99);
				sub = $urandom_range(99);
				if (pick < 60) begin
					if (sub < 6)
						ch = CHAR_LF;
					else if (sub < 10)
						ch = CHAR_CR;
					else if (sub >= 40)
						ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
				end else if (pick < 68) begin
					op = OP_NEWLINE;
				end else if (pick < 70) begin
					op = OP_CLEAR;
				end else begin
					op = OP_READ;
					if (sub < 8)
						idx = IDX_W'($urandom_range(CELL_COUNT, 2047));
					else if (sub < 50)
						idx = IDX_W'(row_now * COLUMNS + $urandom_range(COLUMNS - 1));
					else
						idx = IDX_W'($urandom_range(CELL_COUNT - 1));
				end
			end
			send_item(op, ch, idx, 1'b0, '0);
		end
	endtask

	initial begin
		start = 1'b0;
		operation = OP_PUT;
		character = '0;
		cell_index = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FG;
		cfg_data = '0;
		pin_now = 1'b0;
		pin_result = '0;
		fault_count = 0;
		stall_count = 0;
		idle_pct = 7;
		foreach (screen[i])
			screen[i] = '0;
		row_now = 0;
		col_now = 0;
		fg_now = FG_RESET;
		bg_now = BG_RESET;
		arst_n = 1'b0;

		directed_rows = '{
			'{OP_READ,    8'h00, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd0, 1'b0},
			'{OP_READ,    8'hff, 11'd1999, 1'b1, 16'h0000, 5'd0, 7'd0, 1'b0},
			'{OP_READ,    8'h00, 11'd2047, 1'b1, 16'h0000, 5'd0, 7'd0, 1'b0},
			'{OP_READ,    8'h00, 11'd2000, 1'b1, 16'h0000, 5'd0, 7'd0, 1'b0},
			'{OP_PUT,     8'h41, 11'd2047, 1'b1, 16'h0000, 5'd0, 7'd1, 1'b0},
			'{OP_READ,    8'h00, 11'd0,    1'b1, 16'h0741, 5'd0, 7'd1, 1'b0},
			'{OP_PUT,     8'h00, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd2, 1'b0},
			'{OP_PUT,     8'hff, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd3, 1'b0},
			'{OP_READ,    8'h00, 11'd2,    1'b1, 16'h07ff, 5'd0, 7'd3, 1'b0},
			'{OP_PUT,     CHAR_CR, 11'd0,  1'b1, 16'h0000, 5'd0, 7'd0, 1'b0},
			'{OP_PUT,     CHAR_LF, 11'd0,  1'b1, 16'h0000, 5'd1, 7'd0, 1'b0},
			'{OP_NEWLINE, 8'hff, 11'd2047, 1'b1, 16'h0000, 5'd2, 7'd0, 1'b0},
			'{OP_PUT,     8'h7e, 11'd0,    1'b1, 16'h0000, 5'd2, 7'd1, 1'b0},
			'{OP_READ,    8'h00, 11'd160,  1'b1, 16'h077e, 5'd2, 7'd1, 1'b0},
			'{OP_READ,    8'h00, 11'd1,    1'b1, 16'h0700, 5'd2, 7'd1, 1'b0},
			'{OP_CLEAR,   8'h41, 11'd5,    1'b1, 16'h0000, 5'd0, 7'd0, 1'b0},
			'{OP_READ,    8'h00, 11'd1999, 1'b1, 16'h0720, 5'd0, 7'd0, 1'b0},
			'{OP_READ,    8'h00, 11'd0,    1'b1, 16'h0720, 5'd0, 7'd0, 1'b0},
			'{OP_PUT,     8'h80, 11'd0,    1'b0, 16'h0000, 5'd0, 7'd0, 1'b0},
			'{OP_PUT,     8'h09, 11'd0,    1'b0, 16'h0000, 5'd0, 7'd0, 1'b0},
			'{OP_READ,    8'h00, 11'd1,    1'b0, 16'h0000, 5'd0, 7'd0, 1'b0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].idx,
				directed_rows[i].pinned, {directed_rows[i].cell_val, directed_rows[i].row,
				directed_rows[i].col, directed_rows[i].scr});
		drain_results();

		write_colour(REG_FG, 4'hf);
		write_colour(REG_BG, 4'hf);
		run_random(400);
		drain_results();

		idle_pct = 70;
		write_colour(REG_FG, 4'h0);
		write_colour(REG_BG, 4'h0);
		run_random(400);
		drain_results();

		idle_pct = 0;
		write_colour(REG_FG, CLR_W'($urandom_range(15)));
		write_colour(REG_BG, CLR_W'($urandom_range(15)));
		run_random(200);
		drain_results();
		write_colour(REG_BG, CLR_W'($urandom_range(15)));
		run_random(200);
		drain_results();

		repeat (CELL_COUNT + 16) @(negedge clk);
		while (pending_results.size() != 0) begin
			void'(pending_results.pop_front());
			flag_fault("item left without a result");
		end
		if (fault_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
